[rtl/evre_pkg.sv]
// Package with the types, constants and helper functions of the range estimator.
package evre_pkg;

   // Field widths of the words and registers.
   localparam int unsigned SOC_W   = 10;
   localparam int unsigned CONS_W  = 10;
   localparam int unsigned TEMP_W  = 8;
   localparam int unsigned RANGE_W = 15;
   localparam int unsigned CAP_W   = 18;
   localparam int unsigned EFF_W   = 13;
   localparam int unsigned CSR_W   = 18;
   localparam int unsigned CSR_IDX_W = 2;

   // Datapath widths of the serial multiplier and divider.
   localparam int unsigned TF_W    = 10;
   localparam int unsigned PROD1_W = 28;
   localparam int unsigned ACC_W   = 38;
   localparam int unsigned DEN_W   = 30;
   localparam int unsigned NUM_W   = 43;
   localparam int unsigned CNT_W   = 6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_EFF    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE_SOC = 2'd2;

   // Reset values of the configuration and state.
   localparam logic [CAP_W-1:0] CAPACITY_RST = 18'd77400;
   localparam logic [EFF_W-1:0] EFF_RST      = 13'd2560;
   localparam logic [SOC_W-1:0] RESERVE_RST  = 10'd50;

   // Constants of the arithmetic.
   localparam logic [RANGE_W-1:0] RANGE_MAX   = 15'd20000;
   localparam logic [16:0]        DEN_SCALE   = 17'd100000;
   localparam logic [DEN_W-1:0]   DEN_TEN     = 30'd10;
   localparam logic [CONS_W-1:0]  CONS_LOW    = 10'd50;
   localparam logic [CONS_W-1:0]  CONS_HIGH   = 10'd500;

   // Step counts of the serial units.
   localparam logic [CNT_W-1:0] MUL_STEPS     = 6'd10;
   localparam logic [CNT_W-1:0] EFF_DIV_STEPS = 6'd17;
   localparam logic [CNT_W-1:0] RAW_DIV_STEPS = 6'd43;
   localparam logic [CNT_W-1:0] EMA_DIV_STEPS = 6'd18;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EFF_DIV,
      ST_EFF_WB,
      ST_MUL_A,
      ST_MUL_B,
      ST_DEN,
      ST_DIV_LOAD,
      ST_RAW_DIV,
      ST_RAW_SAT,
      ST_EMA_DIV,
      ST_EMA_WB,
      ST_OUT
   } state_type;

   // Temperature derating in per-mille, by temperature band.
   function automatic logic [TF_W-1:0] temp_factor(input logic signed [TEMP_W-1:0] t);
      logic [TF_W-1:0] f;
      if (t < 8'sd0) begin
         f = 10'd700;
      end else if (t < 8'sd10) begin
         f = 10'd850;
      end else if (t < 8'sd20) begin
         f = 10'd950;
      end else if (t > 8'sd45) begin
         f = 10'd850;
      end else if (t > 8'sd35) begin
         f = 10'd950;
      end else begin
         f = 10'd1000;
      end
      return f;
   endfunction

endpackage

[rtl/evre_if.sv]
// Valid/ready stream interfaces for the sample words and the range words.
interface evre_req_if;
   logic                                valid;
   logic                                ready;
   logic [evre_pkg::SOC_W-1:0]          soc_tenths;
   logic [evre_pkg::CONS_W-1:0]         avg_consumption;
   logic signed [evre_pkg::TEMP_W-1:0]  pack_temp;

   modport source (output valid, output soc_tenths, output avg_consumption,
                   output pack_temp, input ready);
   modport sink   (input valid, input soc_tenths, input avg_consumption,
                   input pack_temp, output ready);
endinterface

interface evre_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [evre_pkg::RANGE_W-1:0]  range_tenths_km;
   logic                          reserve_active;

   modport source (output valid, output range_tenths_km, output reserve_active,
                   input ready);
   modport sink   (input valid, input range_tenths_km, input reserve_active,
                   output ready);
endinterface

[rtl/ev_range_estimator_core.sv]
// Top level of the range estimator: sequencer, serial multiplier and serial divider.
//
// Usage: each word on req_bus carries a charge sample, the average consumption and the
// battery temperature. A word whose charge equals the stored last charge is accepted and
// yields no result. Any other word updates the smoothed efficiency (when the
// consumption lies strictly between 50 and 500 Wh/km), computes a temperature-derated
// range, smooths it against a nonzero previous range and returns one word on rsp_bus.
// A bit-serial shift-add multiplier forms charge times capacity and then times the
// temperature factor, and one bit-serial restoring divider is shared by the
// efficiency average (17 steps), the range quotient (43 steps) and the range average
// (18 steps). The 43-step range division is the longest. The next word is accepted the cycle
// after the result is handed to the output register, so the block takes no new-charge
// word while it is still working on the last one.
// The result sits in an output register; if the receiver stalls, the block still
// finishes the next word and then waits with it until the register frees up.
// Synchronous reset restores capacity 77400 Wh, efficiency 2560 (Q4 Wh/km), reserve
// charge 50, and clears the last charge and previous range. Configuration writes on the
// csr_ port take effect at once and are meant to be issued while the block is idle.
module ev_range_estimator_core (
   input  logic                              clock,
   input  logic                              reset,
   evre_req_if.sink                          req_bus,
   evre_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [evre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [evre_pkg::CSR_W-1:0]        csr_wdata
);

   // Sequencer state.
   evre_pkg::state_type state_ff, state_in;

   // Configuration and persistent state.
   logic [evre_pkg::CAP_W-1:0]   capacity_ff, capacity_in;
   logic [evre_pkg::SOC_W-1:0]   reserve_ff, reserve_in;
   logic [evre_pkg::EFF_W-1:0]   eff_ff, eff_in;
   logic [evre_pkg::SOC_W-1:0]   last_soc_ff, last_soc_in;
   logic [evre_pkg::RANGE_W-1:0] prev_ff, prev_in;

   // Captured word and intermediate range.
   logic [evre_pkg::SOC_W-1:0]   soc_ff, soc_in;
   logic [evre_pkg::TF_W-1:0]    tf_ff, tf_in;
   logic [evre_pkg::RANGE_W-1:0] range_ff, range_in;

   // Serial multiplier.
   logic [evre_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [evre_pkg::PROD1_W-1:0] mcand_ff, mcand_in;
   logic [evre_pkg::TF_W-1:0]    mplier_ff, mplier_in;

   // Serial divider.
   logic [evre_pkg::NUM_W-1:0]   div_num_ff, div_num_in;
   logic [evre_pkg::DEN_W-1:0]   div_den_ff, div_den_in;
   logic [evre_pkg::DEN_W-1:0]   div_rem_ff, div_rem_in;
   logic [evre_pkg::RANGE_W-1:0] quo_ff, quo_in;
   logic                         ovf_ff, ovf_in;

   // Shared step counter.
   logic [evre_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [evre_pkg::RANGE_W-1:0] rsp_range_ff, rsp_range_in;
   logic                         rsp_reserve_ff, rsp_reserve_in;

   // Combinational helpers.
   logic                         req_accept;
   logic                         new_charge;
   logic                         cons_ok;
   logic                         last_step;
   logic                         rsp_load;
   logic [evre_pkg::ACC_W-1:0]   acc_step;
   logic [evre_pkg::DEN_W:0]     trial;
   logic [evre_pkg::DEN_W:0]     diff;
   logic                         qbit;
   logic [16:0]                  eff_sum;
   logic [17:0]                  ema_sum;
   logic [evre_pkg::RANGE_W-1:0] raw_sat;
   logic                         reserve_now;

   // Handshake and decision terms.
   assign req_accept  = req_bus.valid && req_bus.ready;
   assign new_charge  = req_bus.soc_tenths != last_soc_ff;
   assign cons_ok     = (req_bus.avg_consumption > evre_pkg::CONS_LOW)
                        && (req_bus.avg_consumption < evre_pkg::CONS_HIGH);
   assign last_step   = cnt_ff == evre_pkg::CNT_W'(1);
   assign rsp_load    = (state_ff == evre_pkg::ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);
   assign reserve_now = soc_ff < reserve_ff;

   // One multiplier step: shift the accumulator and add the multiplicand on a one bit.
   assign acc_step = {acc_ff[evre_pkg::ACC_W-2:0], 1'b0}
                     + (mplier_ff[evre_pkg::TF_W-1]
                        ? {{(evre_pkg::ACC_W-evre_pkg::PROD1_W){1'b0}}, mcand_ff}
                        : {evre_pkg::ACC_W{1'b0}});

   // One restoring divider step: bring in the next numerator bit and try a subtract.
   assign trial = {div_rem_ff, div_num_ff[evre_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, div_den_ff};
   assign qbit  = trial >= {1'b0, div_den_ff};

   // Efficiency average numerator: 16 * consumption + 9 * efficiency + 5.
   assign eff_sum = {3'b0, req_bus.avg_consumption, 4'b0} + {1'b0, eff_ff, 3'b0}
                    + {4'b0, eff_ff} + 17'd5;

   // Range average numerator: 2 * raw + 8 * previous + 5.
   assign ema_sum = {2'b0, raw_sat, 1'b0} + {prev_ff, 3'b0} + 18'd5;

   // Saturated raw range from the quotient and its overflow flag.
   assign raw_sat = (ovf_ff || (quo_ff > evre_pkg::RANGE_MAX)) ? evre_pkg::RANGE_MAX : quo_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         evre_pkg::ST_IDLE: begin
            if (req_accept && new_charge) begin
               state_in = cons_ok ? evre_pkg::ST_EFF_DIV : evre_pkg::ST_MUL_A;
            end
         end
         evre_pkg::ST_EFF_DIV: begin
            if (last_step) begin
               state_in = evre_pkg::ST_EFF_WB;
            end
         end
         evre_pkg::ST_EFF_WB: begin
            state_in = evre_pkg::ST_MUL_A;
         end
         evre_pkg::ST_MUL_A: begin
            if (last_step) begin
               state_in = evre_pkg::ST_MUL_B;
            end
         end
         evre_pkg::ST_MUL_B: begin
            if (last_step) begin
               state_in = evre_pkg::ST_DEN;
            end
         end
         evre_pkg::ST_DEN: begin
            state_in = evre_pkg::ST_DIV_LOAD;
         end
         evre_pkg::ST_DIV_LOAD: begin
            state_in = evre_pkg::ST_RAW_DIV;
         end
         evre_pkg::ST_RAW_DIV: begin
            if (last_step) begin
               state_in = evre_pkg::ST_RAW_SAT;
            end
         end
         evre_pkg::ST_RAW_SAT: begin
            state_in = (prev_ff != '0) ? evre_pkg::ST_EMA_DIV : evre_pkg::ST_OUT;
         end
         evre_pkg::ST_EMA_DIV: begin
            if (last_step) begin
               state_in = evre_pkg::ST_EMA_WB;
            end
         end
         evre_pkg::ST_EMA_WB: begin
            state_in = evre_pkg::ST_OUT;
         end
         evre_pkg::ST_OUT: begin
            if (rsp_load) begin
               state_in = evre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = evre_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_bus.ready           = state_ff == evre_pkg::ST_IDLE;
      rsp_bus.valid           = rsp_valid_ff;
      rsp_bus.range_tenths_km = rsp_range_ff;
      rsp_bus.reserve_active  = rsp_reserve_ff;
   end

   // Datapath next values per state.
   always_comb begin
      capacity_in    = capacity_ff;
      reserve_in     = reserve_ff;
      eff_in         = eff_ff;
      last_soc_in    = last_soc_ff;
      prev_in        = prev_ff;
      soc_in         = soc_ff;
      tf_in          = tf_ff;
      range_in       = range_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      div_num_in     = div_num_ff;
      div_den_in     = div_den_ff;
      div_rem_in     = div_rem_ff;
      quo_in         = quo_ff;
      ovf_in         = ovf_ff;
      cnt_in         = cnt_ff;
      rsp_range_in   = rsp_range_ff;
      rsp_reserve_in = rsp_reserve_ff;

      // Configuration writes; unknown indexes are ignored.
      if (csr_we) begin
         case (csr_index)
            evre_pkg::CSR_CAPACITY:    capacity_in = csr_wdata[evre_pkg::CAP_W-1:0];
            evre_pkg::CSR_INIT_EFF:    eff_in      = csr_wdata[evre_pkg::EFF_W-1:0];
            evre_pkg::CSR_RESERVE_SOC: reserve_in  = csr_wdata[evre_pkg::SOC_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         evre_pkg::ST_IDLE: begin
            // Capture a new charge and start either the efficiency average or the product.
            if (req_accept && new_charge) begin
               soc_in      = req_bus.soc_tenths;
               last_soc_in = req_bus.soc_tenths;
               tf_in       = evre_pkg::temp_factor(req_bus.pack_temp);
               div_rem_in  = '0;
               quo_in      = '0;
               ovf_in      = 1'b0;
               div_num_in  = {eff_sum, 26'b0};
               div_den_in  = evre_pkg::DEN_TEN;
               acc_in      = '0;
               mcand_in    = {{(evre_pkg::PROD1_W-evre_pkg::CAP_W){1'b0}}, capacity_ff};
               mplier_in   = req_bus.soc_tenths;
               cnt_in      = cons_ok ? evre_pkg::EFF_DIV_STEPS : evre_pkg::MUL_STEPS;
            end
         end
         evre_pkg::ST_EFF_DIV, evre_pkg::ST_RAW_DIV, evre_pkg::ST_EMA_DIV: begin
            // Shared divider step.
            div_num_in = {div_num_ff[evre_pkg::NUM_W-2:0], 1'b0};
            div_rem_in = qbit ? diff[evre_pkg::DEN_W-1:0] : trial[evre_pkg::DEN_W-1:0];
            quo_in     = {quo_ff[evre_pkg::RANGE_W-2:0], qbit};
            ovf_in     = ovf_ff | quo_ff[evre_pkg::RANGE_W-1];
            cnt_in     = cnt_ff - evre_pkg::CNT_W'(1);
         end
         evre_pkg::ST_EFF_WB: begin
            // Store the new efficiency and set up charge times capacity.
            eff_in    = quo_ff[evre_pkg::EFF_W-1:0];
            acc_in    = '0;
            mcand_in  = {{(evre_pkg::PROD1_W-evre_pkg::CAP_W){1'b0}}, capacity_ff};
            mplier_in = soc_ff;
            cnt_in    = evre_pkg::MUL_STEPS;
         end
         evre_pkg::ST_MUL_A: begin
            // Charge times capacity; then reload for the temperature factor.
            acc_in    = acc_step;
            mplier_in = {mplier_ff[evre_pkg::TF_W-2:0], 1'b0};
            cnt_in    = cnt_ff - evre_pkg::CNT_W'(1);
            if (last_step) begin
               acc_in    = '0;
               mcand_in  = acc_step[evre_pkg::PROD1_W-1:0];
               mplier_in = tf_ff;
               cnt_in    = evre_pkg::MUL_STEPS;
            end
         end
         evre_pkg::ST_MUL_B: begin
            acc_in    = acc_step;
            mplier_in = {mplier_ff[evre_pkg::TF_W-2:0], 1'b0};
            cnt_in    = cnt_ff - evre_pkg::CNT_W'(1);
         end
         evre_pkg::ST_DEN: begin
            // Denominator: efficiency times 100000.
            div_den_in = {{(evre_pkg::DEN_W-evre_pkg::EFF_W){1'b0}}, eff_ff}
                         * evre_pkg::DEN_W'(evre_pkg::DEN_SCALE);
         end
         evre_pkg::ST_DIV_LOAD: begin
            // Numerator is the product times 16 plus half the denominator for rounding.
            div_num_in = {1'b0, acc_ff, 4'b0}
                         + {{(evre_pkg::NUM_W-evre_pkg::DEN_W+1){1'b0}},
                            div_den_ff[evre_pkg::DEN_W-1:1]};
            div_rem_in = '0;
            quo_in     = '0;
            ovf_in     = 1'b0;
            cnt_in     = evre_pkg::RAW_DIV_STEPS;
         end
         evre_pkg::ST_RAW_SAT: begin
            // Saturate and set up the range average when there is a previous range.
            range_in   = raw_sat;
            div_num_in = {ema_sum, 25'b0};
            div_den_in = evre_pkg::DEN_TEN;
            div_rem_in = '0;
            quo_in     = '0;
            ovf_in     = 1'b0;
            cnt_in     = evre_pkg::EMA_DIV_STEPS;
         end
         evre_pkg::ST_EMA_WB: begin
            range_in = quo_ff;
         end
         evre_pkg::ST_OUT: begin
            // Hand the word to the output register and remember the range.
            if (rsp_load) begin
               prev_in        = range_ff;
               rsp_range_in   = reserve_now ? '0 : range_ff;
               rsp_reserve_in = reserve_now;
            end
         end
         default: ;
      endcase
   end

   // Output register valid flag.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and persistent state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= evre_pkg::ST_IDLE;
         capacity_ff  <= evre_pkg::CAPACITY_RST;
         reserve_ff   <= evre_pkg::RESERVE_RST;
         eff_ff       <= evre_pkg::EFF_RST;
         last_soc_ff  <= '0;
         prev_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         reserve_ff   <= reserve_in;
         eff_ff       <= eff_in;
         last_soc_ff  <= last_soc_in;
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      soc_ff         <= soc_in;
      tf_ff          <= tf_in;
      range_ff       <= range_in;
      acc_ff         <= acc_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      div_num_ff     <= div_num_in;
      div_den_ff     <= div_den_in;
      div_rem_ff     <= div_rem_in;
      quo_ff         <= quo_in;
      ovf_ff         <= ovf_in;
      rsp_range_ff   <= rsp_range_in;
      rsp_reserve_ff <= rsp_reserve_in;
   end

   // The delivered range never exceeds the saturation limit.
   a_range_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_range_ff <= evre_pkg::RANGE_MAX))
      else $error("range word above limit");

   // A reserve word always carries a zero range.
   a_reserve_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_reserve_ff) |-> (rsp_range_ff == '0))
      else $error("reserve word with nonzero range");

   // The stored previous range stays within the limit.
   a_prev_limit: assert property (@(posedge clock) disable iff (reset)
      prev_ff <= evre_pkg::RANGE_MAX)
      else $error("previous range above limit");

   // A new charge is remembered right after it is accepted.
   a_last_soc: assert property (@(posedge clock) disable iff (reset)
      (req_accept && new_charge) |=> (last_soc_ff == $past(req_bus.soc_tenths)))
      else $error("last charge not updated");

   // The range division and the second multiplier pass only run with a live step count.
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == evre_pkg::ST_RAW_DIV || state_ff == evre_pkg::ST_MUL_B) |-> (cnt_ff != '0))
      else $error("serial unit running with zero step count");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the range estimator: directed and random charge samples.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [evre_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned SETTLE_CYCLES  = 120;
   localparam int unsigned TIMEOUT_CYCLES = 2000000;
   localparam int unsigned WORDS_PER_SETTING = 185;
   localparam int unsigned MAX_GAP = 40;

   // One expected or observed result word.
   typedef struct {
      logic [evre_pkg::RANGE_W-1:0] range_tenths_km;
      logic                         reserve_active;
   } range_word_type;

   // Tracks the estimator state and the queue of range words still to come.
   class range_scoreboard_type;
      logic [evre_pkg::CAP_W-1:0]   capacity;
      logic [evre_pkg::SOC_W-1:0]   reserve_soc;
      logic [evre_pkg::SOC_W-1:0]   last_soc;
      logic [evre_pkg::EFF_W-1:0]   smooth_eff;
      logic [evre_pkg::RANGE_W-1:0] prev_range;
      range_word_type               expected_ranges[$];
      int unsigned                  mismatches;

      function new();
         capacity    = evre_pkg::CAPACITY_RST;
         reserve_soc = evre_pkg::RESERVE_RST;
         last_soc    = '0;
         smooth_eff  = evre_pkg::EFF_RST;
         prev_range  = '0;
         mismatches  = 0;
      endfunction

      // Register writes; loading the start efficiency also restarts the average.
      function void write_reg(logic [evre_pkg::CSR_IDX_W-1:0] idx,
                              logic [evre_pkg::CSR_W-1:0] data);
         case (idx)
            evre_pkg::CSR_CAPACITY: begin
               capacity = data[evre_pkg::CAP_W-1:0];
            end
            evre_pkg::CSR_INIT_EFF: begin
               smooth_eff = data[evre_pkg::EFF_W-1:0];
            end
            evre_pkg::CSR_RESERVE_SOC: begin
               reserve_soc = data[evre_pkg::SOC_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Computes the range word that an accepted sample will produce, if any.
      function void note_sample(logic [evre_pkg::SOC_W-1:0] soc,
                                logic [evre_pkg::CONS_W-1:0] cons,
                                logic signed [evre_pkg::TEMP_W-1:0] temp);
         range_word_type word;
         logic [63:0] ema;
         logic [63:0] permille;
         logic [63:0] num;
         logic [63:0] den;
         logic [63:0] raw;
         logic [63:0] blended;
         if (soc == last_soc) begin
            return;
         end
         last_soc = soc;

         // Efficiency average with alpha 0.1, only for plausible consumption.
         if (cons > evre_pkg::CONS_LOW && cons < evre_pkg::CONS_HIGH) begin
            ema = (64'd16 * 64'(cons) + 64'd9 * 64'(smooth_eff) + 64'd5) / 64'd10;
            smooth_eff = ema[evre_pkg::EFF_W-1:0];
         end

         // Temperature derating bands.
         if (temp < 0) begin
            permille = 64'd700;
         end else if (temp < 10) begin
            permille = 64'd850;
         end else if (temp < 20) begin
            permille = 64'd950;
         end else if (temp > 45) begin
            permille = 64'd850;
         end else if (temp > 35) begin
            permille = 64'd950;
         end else begin
            permille = 64'd1000;
         end

         // Raw range, rounded half up; a zero efficiency saturates it.
         if (smooth_eff == '0) begin
            raw = 64'(evre_pkg::RANGE_MAX);
         end else begin
            num = 64'(soc) * 64'(capacity) * 64'd16 * permille;
            den = 64'd100000 * 64'(smooth_eff);
            raw = (num + den / 64'd2) / den;
            if (raw > 64'(evre_pkg::RANGE_MAX)) begin
               raw = 64'(evre_pkg::RANGE_MAX);
            end
         end

         // Blend with the previous range once one exists.
         if (prev_range > 0) begin
            blended = (64'd2 * raw + 64'd8 * 64'(prev_range) + 64'd5) / 64'd10;
         end else begin
            blended = raw;
         end
         if (blended > 64'(evre_pkg::RANGE_MAX)) begin
            blended = 64'(evre_pkg::RANGE_MAX);
         end
         prev_range = blended[evre_pkg::RANGE_W-1:0];

         if (soc < reserve_soc) begin
            word.range_tenths_km = '0;
            word.reserve_active  = 1'b1;
         end else begin
            word.range_tenths_km = blended[evre_pkg::RANGE_W-1:0];
            word.reserve_active  = 1'b0;
         end
         expected_ranges.push_back(word);
      endfunction

      // Compares a delivered word with the oldest expected one.
      function void check_word(logic [evre_pkg::RANGE_W-1:0] range_km, logic reserve);
         range_word_type want;
         if (expected_ranges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected range word: range %0d reserve %0d", range_km, reserve);
            end
            return;
         end
         want = expected_ranges.pop_front();
         if (want.range_tenths_km !== range_km || want.reserve_active !== reserve) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Range word mismatch: expected range %0d reserve %0d, %s %0d %s %0d",
                        want.range_tenths_km, want.reserve_active, "got range", range_km,
                        "reserve", reserve);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [evre_pkg::CSR_IDX_W-1:0] csr_index;
   logic [evre_pkg::CSR_W-1:0] csr_wdata;

   evre_req_if req_bus();
   evre_rsp_if rsp_bus();

   range_scoreboard_type scoreboard = new();

   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned cycle_count = 0;
   logic [evre_pkg::SOC_W-1:0] last_soc_sent;

   ev_range_estimator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a 2 ns period.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Receiver stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Observe register writes and both handshakes at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            scoreboard.write_reg(csr_index, csr_wdata);
         end
         if (req_bus.valid && req_bus.ready) begin
            scoreboard.note_sample(req_bus.soc_tenths, req_bus.avg_consumption,
                                   req_bus.pack_temp);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            scoreboard.check_word(rsp_bus.range_tenths_km, rsp_bus.reserve_active);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Sends one sample word, idling first at random.
   task automatic send_sample(input logic [evre_pkg::SOC_W-1:0] soc,
                              input logic [evre_pkg::CONS_W-1:0] cons,
                              input logic signed [evre_pkg::TEMP_W-1:0] temp);
      int unsigned gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.soc_tenths      <= soc;
      req_bus.avg_consumption <= cons;
      req_bus.pack_temp       <= temp;
      last_soc_sent = soc;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Holds one register write for a single edge.
   task automatic csr_write(input logic [evre_pkg::CSR_IDX_W-1:0] idx,
                            input logic [evre_pkg::CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Waits until every expected word has arrived and the block has gone quiet.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (scoreboard.expected_ranges.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Programs one register setting; the unused index is written too and must be ignored.
   task automatic apply_setting(input int unsigned k);
      logic [evre_pkg::CSR_W-1:0] cap;
      logic [evre_pkg::CSR_W-1:0] eff;
      logic [evre_pkg::CSR_W-1:0] rsv;
      case (k)
         0: begin cap = 18'd77400;  eff = 18'd2560; rsv = 18'd50;   end
         1: begin cap = 18'd1000;   eff = 18'd801;  rsv = 18'd0;    end
         2: begin cap = 18'd200000; eff = 18'd8000; rsv = 18'd1000; end
         3: begin cap = 18'd262143; eff = 18'd8191; rsv = 18'd1023; end
         4: begin
            cap = evre_pkg::CSR_W'($urandom_range(1000, 200000));
            eff = 18'd0;
            rsv = evre_pkg::CSR_W'($urandom_range(0, 100));
         end
         5: begin cap = 18'd0; eff = 18'd1; rsv = 18'd0; end
         6: begin
            cap = evre_pkg::CSR_W'($urandom_range(1000, 200000));
            eff = evre_pkg::CSR_W'($urandom_range(801, 8000));
            rsv = evre_pkg::CSR_W'($urandom_range(0, 200));
         end
         7: begin
            cap = evre_pkg::CSR_W'($urandom_range(1000, 30000));
            eff = evre_pkg::CSR_W'($urandom_range(801, 8000));
            rsv = evre_pkg::CSR_W'($urandom_range(0, 1000));
         end
         default: begin
            cap = evre_pkg::CSR_W'($urandom_range(0, 262143));
            eff = evre_pkg::CSR_W'($urandom_range(0, 8191));
            rsv = evre_pkg::CSR_W'($urandom_range(0, 1023));
         end
      endcase
      csr_write(evre_pkg::CSR_CAPACITY, cap);
      csr_write(evre_pkg::CSR_INIT_EFF, eff);
      csr_write(evre_pkg::CSR_RESERVE_SOC, rsv);
      csr_write(CSR_UNUSED, evre_pkg::CSR_W'($urandom_range(0, 262143)));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random driving profile: slow discharge with jumps, repeats and recharges.
   task automatic drive_random(input int unsigned count, input int unsigned window_pct);
      int unsigned fresh;
      int unsigned pick;
      logic [evre_pkg::SOC_W-1:0] soc;
      logic [evre_pkg::CONS_W-1:0] cons;
      logic signed [evre_pkg::TEMP_W-1:0] temp;
      fresh = 0;
      while (fresh < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            soc = last_soc_sent;
         end else if (pick < 22) begin
            soc = evre_pkg::SOC_W'($urandom_range(0, 1023));
         end else if (last_soc_sent < 10) begin
            soc = evre_pkg::SOC_W'($urandom_range(850, 1000));
         end else begin
            soc = last_soc_sent - evre_pkg::SOC_W'($urandom_range(1, 9));
         end
         if ($urandom_range(0, 99) < window_pct) begin
            cons = evre_pkg::CONS_W'($urandom_range(51, 499));
         end else begin
            cons = evre_pkg::CONS_W'($urandom_range(0, 1023));
         end
         if ($urandom_range(0, 9) == 0) begin
            temp = evre_pkg::TEMP_W'($urandom_range(0, 255));
         end else begin
            temp = evre_pkg::TEMP_W'($urandom_range(0, 165) - 40);
         end
         if (soc != last_soc_sent) begin
            fresh++;
         end
         send_sample(soc, cons, temp);
      end
   endtask

   // Main sequence.
   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= evre_pkg::CSR_CAPACITY;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.soc_tenths      <= '0;
      req_bus.avg_consumption <= '0;
      req_bus.pack_temp       <= '0;
      last_soc_sent     = '0;
      send_idle_pct     = 25;
      rsp_idle_pct      = 62;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples at the reset configuration.
      send_sample(10'd0, 10'd100, 8'sd25);      // same charge as after reset: no word
      send_sample(10'd1000, 10'd0, 8'sd25);
      send_sample(10'd1000, 10'd300, 8'sd25);   // repeated charge
      send_sample(10'd999, 10'd50, -8'sd40);    // consumption at the lower bound
      send_sample(10'd998, 10'd51, -8'sd1);
      send_sample(10'd997, 10'd499, 8'sd0);
      send_sample(10'd996, 10'd500, 8'sd9);     // consumption at the upper bound
      send_sample(10'd995, 10'd1023, 8'sd10);
      send_sample(10'd994, 10'd200, 8'sd19);
      send_sample(10'd993, 10'd200, 8'sd20);
      send_sample(10'd992, 10'd200, 8'sd35);
      send_sample(10'd991, 10'd200, 8'sd36);
      send_sample(10'd990, 10'd200, 8'sd45);
      send_sample(10'd989, 10'd200, 8'sd46);
      send_sample(10'd988, 10'd200, 8'sd125);
      send_sample(10'd987, 10'd200, -8'sd128);
      send_sample(10'd986, 10'd200, 8'sd127);
      send_sample(10'd1023, 10'd682, 8'sd85);   // charge beyond full
      send_sample(10'd50, 10'd341, 8'sd42);     // just at the reserve level
      send_sample(10'd49, 10'd150, 8'sd25);     // inside the reserve
      send_sample(10'd0, 10'd150, 8'sd25);
      send_sample(10'd512, 10'd0, 8'sd25);
      settle();

      // Random phases: three idle profiles with three register settings each.
      for (int unsigned k = 0; k < 9; k++) begin
         if (k == 3) begin
            send_idle_pct = 62;
            rsp_idle_pct  = 25;
         end else if (k == 6) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         apply_setting(k);
         drive_random(WORDS_PER_SETTING, (k == 4) ? 3 : 45);
         settle();
      end

      if (scoreboard.mismatches == 0 && scoreboard.expected_ranges.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[ev_range_estimator_core.f]
rtl/evre_pkg.sv
rtl/evre_if.sv
rtl/ev_range_estimator_core.sv
bench/testbench.sv
